// ===== hw/rtl/linked_pool_allocator_defines.svh =====
// Assertion macros used by the linked pool allocator RTL.
`ifndef LINKED_POOL_ALLOCATOR_DEFINES_SVH
`define LINKED_POOL_ALLOCATOR_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LPA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define LPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lpa_pkg.sv =====
// Types and constants of the linked pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package lpa_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    OP_ALLOC_HEAD = 2'd0,
    OP_ALLOC_TAIL = 2'd1,
    OP_RELEASE    = 2'd2,
    OP_NEXT       = 2'd3
  } lpa_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpa_if.sv =====
// Request and response channel interfaces of the linked pool allocator.
`timescale 1ns / 1ps
`default_nettype none

interface lpa_req_if;
  import lpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] node_index;
  logic             from_start;

  modport source (output valid, output opcode, output node_index, output from_start,
                  input ready);
  modport sink (input valid, input opcode, input node_index, input from_start,
                output ready);
endinterface

interface lpa_rsp_if;
  import lpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic             result_valid;
  logic [CNT_W-1:0] count_in_use;
  logic             error;

  modport source (output valid, output result_index, output result_valid,
                  output count_in_use, output error, input ready);
  modport sink (input valid, input result_index, input result_valid,
                input count_in_use, input error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/linked_pool_allocator.sv =====
// Top level of the linked pool allocator: slot lists, link memories and handshake.
// The block manages POOL_SIZE slots held on a free queue and a doubly linked in-use list.
// Requests arrive on req as one beat each: allocate at head, allocate at tail,
// release a slot, or ask for the successor of a node (or the list head).
// Every request gives exactly one response beat on rsp with the slot found,
// a flag telling whether it is meaningful, the in-use count and a release error flag.
// A request is taken into an input register while the link memories are read;
// when rsp can take a beat, the lists are updated and the response register is
// loaded, and one request a cycle is sustained while rsp takes each beat.
// Back-to-back requests see each other's link writes through a one-entry bypass
// in front of each memory.
// Slots never yet handed out are counted by a fill pointer, so reset needs no
// clearing pass: after reset every slot is free, in order, and the block is ready
// in the first cycle. Reset drops any response not yet taken.
// When rsp stalls, the response register and the input register hold one request
// each, and req is held off until rsp takes its beat.
`timescale 1ns / 1ps
`default_nettype none
`include "linked_pool_allocator_defines.svh"

module linked_pool_allocator #(
  parameter int POOL_SIZE = 64
) (
  input wire logic clk,
  input wire logic rst,
  lpa_req_if.sink   req,
  lpa_rsp_if.source rsp
);
  import lpa_pkg::*;

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int SW = (AW > IDX_W) ? AW : IDX_W;
  localparam int KW = (CW > CNT_W) ? CW : CNT_W;

  // Input register.
  logic             b_valid;
  lpa_op_t          op_q;
  logic [IDX_W-1:0] idx_q;
  logic             start_q;

  // List state.
  logic [AW-1:0] used_head, used_head_next;
  logic [AW-1:0] used_tail, used_tail_next;
  logic [CW-1:0] used_total, used_total_next;
  logic [CW-1:0] fresh, fresh_next;
  logic [AW-1:0] rec_head, rec_head_next;
  logic [AW-1:0] rec_last, rec_last_next;
  logic          rec_valid, rec_valid_next;

  // Memory ports.
  logic          un_we, pv_we, fn_we, iu_we;
  logic [AW-1:0] un_wa, pv_wa, fn_wa, iu_wa;
  logic [AW-1:0] un_wd, pv_wd, fn_wd;
  logic          iu_wd;
  logic [AW-1:0] un_rd, pv_rd, fn_rd;
  logic          iu_rd;
  logic [AW-1:0] in_addr, fn_raddr;

  // Bypass of the write that coincides with the read.
  logic          un_hit, pv_hit, fn_hit, iu_hit;
  logic [AW-1:0] un_byp, pv_byp, fn_byp;
  logic          iu_byp;
  logic [AW-1:0] un_d, pv_d, fn_d;
  logic          iu_d;

  logic          b_fire, in_fire;
  logic          idx_ok, idx_live, list_nonempty, fresh_avail, free_ok;
  logic [AW-1:0] idx_a, slot;
  logic          res_ok, err;
  logic [AW-1:0] res_slot;
  logic [SW-1:0] slot_x;
  logic [KW-1:0] cnt_x;

  assign b_fire    = b_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !b_valid || b_fire;
  assign in_fire   = req.valid && req.ready;
  assign in_addr   = AW'(req.node_index);
  assign fn_raddr  = b_fire ? rec_head_next : rec_head;

  assign un_d = un_hit ? un_byp : un_rd;
  assign pv_d = pv_hit ? pv_byp : pv_rd;
  assign fn_d = fn_hit ? fn_byp : fn_rd;
  assign iu_d = iu_hit ? iu_byp : iu_rd;

  assign idx_a         = AW'(idx_q);
  assign idx_ok        = int'(idx_q) < POOL_SIZE;
  assign idx_live      = idx_ok && (CW'(idx_a) < fresh) && iu_d;
  assign list_nonempty = (used_total != '0);
  assign fresh_avail   = fresh < CW'(POOL_SIZE);
  assign free_ok       = fresh_avail || rec_valid;
  assign slot          = fresh_avail ? fresh[AW-1:0] : rec_head;

  always_comb begin
    used_head_next  = used_head;
    used_tail_next  = used_tail;
    used_total_next = used_total;
    fresh_next      = fresh;
    rec_head_next   = rec_head;
    rec_last_next   = rec_last;
    rec_valid_next  = rec_valid;
    un_we = 1'b0; un_wa = slot; un_wd = used_head;
    pv_we = 1'b0; pv_wa = slot; pv_wd = used_tail;
    fn_we = 1'b0; fn_wa = rec_last; fn_wd = idx_a;
    iu_we = 1'b0; iu_wa = slot; iu_wd = 1'b1;
    res_ok   = 1'b0;
    res_slot = slot;
    err      = 1'b0;
    unique case (op_q) inside
      OP_ALLOC_HEAD, OP_ALLOC_TAIL: begin
        if (free_ok) begin
          res_ok          = 1'b1;
          used_total_next = used_total + 1'b1;
          iu_we           = 1'b1;
          if (fresh_avail) begin
            fresh_next = fresh + 1'b1;
          end else begin
            rec_head_next = fn_d;
            if (rec_head == rec_last) begin
              rec_valid_next = 1'b0;
            end
          end
          if (op_q == OP_ALLOC_HEAD) begin
            if (list_nonempty) begin
              un_we = 1'b1; un_wa = slot;      un_wd = used_head;
              pv_we = 1'b1; pv_wa = used_head; pv_wd = slot;
            end else begin
              used_tail_next = slot;
            end
            used_head_next = slot;
          end else begin
            if (list_nonempty) begin
              un_we = 1'b1; un_wa = used_tail; un_wd = slot;
              pv_we = 1'b1; pv_wa = slot;      pv_wd = used_tail;
            end else begin
              used_head_next = slot;
            end
            used_tail_next = slot;
          end
        end
      end
      OP_RELEASE: begin
        if (!idx_live) begin
          err = 1'b1;
        end else begin
          if (idx_a != used_tail) begin
            pv_we = 1'b1; pv_wa = un_d; pv_wd = pv_d;
          end else begin
            used_tail_next = pv_d;
          end
          if (idx_a != used_head) begin
            un_we = 1'b1; un_wa = pv_d; un_wd = un_d;
          end else begin
            used_head_next = un_d;
          end
          if (rec_valid) begin
            fn_we = 1'b1; fn_wa = rec_last; fn_wd = idx_a;
          end else begin
            rec_head_next = idx_a;
          end
          rec_last_next   = idx_a;
          rec_valid_next  = 1'b1;
          iu_we           = 1'b1;
          iu_wa           = idx_a;
          iu_wd           = 1'b0;
          used_total_next = used_total - 1'b1;
        end
      end
      OP_NEXT: begin
        if (start_q) begin
          res_ok   = list_nonempty;
          res_slot = used_head;
        end else if (idx_live && (idx_a != used_tail)) begin
          res_ok   = 1'b1;
          res_slot = un_d;
        end
      end
    endcase
  end

  assign slot_x = SW'(res_slot);
  assign cnt_x  = KW'(used_total_next);

  lpa_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_used_next (
    .clk(clk), .we(un_we && b_fire), .waddr(un_wa), .wdata(un_wd),
    .re(in_fire), .raddr(in_addr), .rdata(un_rd)
  );

  lpa_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_prev_link (
    .clk(clk), .we(pv_we && b_fire), .waddr(pv_wa), .wdata(pv_wd),
    .re(in_fire), .raddr(in_addr), .rdata(pv_rd)
  );

  lpa_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_free_next (
    .clk(clk), .we(fn_we && b_fire), .waddr(fn_wa), .wdata(fn_wd),
    .re(in_fire), .raddr(fn_raddr), .rdata(fn_rd)
  );

  lpa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_in_use (
    .clk(clk), .we(iu_we && b_fire), .waddr(iu_wa), .wdata(iu_wd),
    .re(in_fire), .raddr(in_addr), .rdata(iu_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      rsp.valid  <= 1'b0;
      used_head  <= '0;
      used_tail  <= '0;
      used_total <= '0;
      fresh      <= '0;
      rec_head   <= '0;
      rec_last   <= '0;
      rec_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        rsp.valid  <= 1'b1;
        used_head  <= used_head_next;
        used_tail  <= used_tail_next;
        used_total <= used_total_next;
        fresh      <= fresh_next;
        rec_head   <= rec_head_next;
        rec_last   <= rec_last_next;
        rec_valid  <= rec_valid_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_NEXT;
    end else if (in_fire) begin
      op_q    <= lpa_op_t'(req.opcode);
      idx_q   <= req.node_index;
      start_q <= req.from_start;
      un_hit  <= un_we && b_fire && (un_wa == in_addr);
      pv_hit  <= pv_we && b_fire && (pv_wa == in_addr);
      iu_hit  <= iu_we && b_fire && (iu_wa == in_addr);
      fn_hit  <= fn_we && b_fire && (fn_wa == fn_raddr);
      un_byp  <= un_wd;
      pv_byp  <= pv_wd;
      iu_byp  <= iu_wd;
      fn_byp  <= fn_wd;
    end
    if (b_fire) begin
      rsp.result_index <= res_ok ? slot_x[IDX_W-1:0] : '0;
      rsp.result_valid <= res_ok;
      rsp.count_in_use <= cnt_x[CNT_W-1:0];
      rsp.error        <= err;
    end
  end

  `LPA_ASSERT_ALWAYS(a_total_in_pool, int'(used_total) <= POOL_SIZE, "in-use count exceeds pool")
  `LPA_ASSERT_ALWAYS(a_free_slot_known, (int'(used_total) >= POOL_SIZE) || fresh_avail || rec_valid, "free slots exist but none is reachable")
  `LPA_ASSERT_NEXT(a_alloc_counts, b_fire && res_ok && (op_q == OP_ALLOC_HEAD || op_q == OP_ALLOC_TAIL), used_total == $past(used_total) + 1'b1, "allocation did not raise the count")
  `LPA_ASSERT_NEXT(a_bad_release_holds, b_fire && err, $stable(used_total) && $stable(fresh) && $stable(rec_valid) && $stable(rec_last), "rejected release changed the lists")
  `LPA_ASSERT_NEXT(a_beat_gives_rsp, b_fire, rsp.valid, "processed request left no response")

endmodule

`default_nettype wire
